// ===== hdl/s2i_pkg.sv =====
// s2i_pkg: types, character codes and the digit decoder of the string to integer parser.
// No dependencies; the input stage, the core, the top level and the testbench import it.
`default_nettype none

package s2i_pkg;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       start_req;
    logic [5:0] radix;
  } s2i_item_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [5:0] BASE_HEX = 6'd16;

  localparam logic [7:0] DIGIT_NONE   = 8'hff;
  localparam logic [7:0] LETTER_VALUE = 8'd10;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      d = c - CH_LA + LETTER_VALUE;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      d = c - CH_UA + LETTER_VALUE;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/s2i_in_if.sv =====
// s2i_in_if: character channel of the parser, valid/ready with one character per beat.
// No dependencies.
`default_nettype none

interface s2i_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;
  logic [5:0] radix;

  modport source (output valid, output ch, output start_req, output radix, input ready);
  modport sink   (input valid, input ch, input start_req, input radix, output ready);
endinterface

`default_nettype wire

// ===== hdl/s2i_out_if.sv =====
// s2i_out_if: result channel of the parser, valid/ready with one parsed value per beat.
// No dependencies.
`default_nettype none

interface s2i_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic        [15:0] end_offset;

  modport source (output valid, output value, output end_offset, input ready);
  modport sink   (input valid, input value, input end_offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/s2i_in_stage.sv =====
// s2i_in_stage: input register of the parser; holds one character beat for the core.
// Depends on s2i_pkg and s2i_in_if.
`default_nettype none

module s2i_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  s2i_in_if.sink            chars,
  input  wire logic         advance,
  output s2i_pkg::s2i_item_t held
);
  import s2i_pkg::*;

  assign chars.ready = !held.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (chars.ready) begin
      held.valid <= chars.valid;
    end
    if (chars.ready) begin
      held.ch        <= chars.ch;
      held.start_req <= chars.start_req;
      held.radix     <= chars.radix;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/s2i_core.sv =====
// s2i_core: parse state machine, multiply-add accumulator and result register.
// Depends on s2i_pkg and s2i_out_if.
`default_nettype none

module s2i_core #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire s2i_pkg::s2i_item_t held,
  output logic                    advance,
  s2i_out_if.source               results
);
  import s2i_pkg::*;

  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [5:0]             active_base, active_base_next;
  logic [63:0]            accumulator, accumulator_next;
  logic [OFFSET_BITS-1:0] consumed, consumed_next;

  logic                   out_valid;
  logic signed [63:0]     out_value;
  logic [15:0]            out_offset;

  phase_t                 ph0;
  logic                   neg0;
  logic [5:0]             base0;
  logic [63:0]            acc0;
  logic [OFFSET_BITS-1:0] cnt0;
  logic [OFFSET_BITS+15:0] cnt_ext;

  logic       is_ws, is_sign, is_x;
  logic       lead_hold, lead_sign, at_prefix, prefix_zero, at_zero, zero_x, at_digits;
  logic [5:0] dig_base;
  logic [7:0] dig;
  logic       dig_ok, take_digit, emit, count, step;

  assign advance = !out_valid || results.ready;
  assign step    = held.valid && advance;

  // a start beat restarts the string before the character itself is looked at
  always_comb begin
    if (held.start_req) begin
      ph0   = PH_LEAD;
      neg0  = 1'b0;
      base0 = held.radix;
      acc0  = '0;
      cnt0  = '0;
    end else begin
      ph0   = phase;
      neg0  = negative;
      base0 = active_base;
      acc0  = accumulator;
      cnt0  = consumed;
    end
  end

  always_comb begin
    is_ws       = (held.ch == CH_SPACE) || (held.ch == CH_TAB);
    is_sign     = (held.ch == CH_MINUS) || (held.ch == CH_PLUS);
    is_x        = (held.ch == CH_LX) || (held.ch == CH_UX);
    lead_hold   = (ph0 == PH_LEAD) && is_ws;
    lead_sign   = (ph0 == PH_LEAD) && !is_ws && is_sign;
    at_prefix   = (ph0 == PH_PREFIX) || ((ph0 == PH_LEAD) && !is_ws && !is_sign);
    prefix_zero = at_prefix && (base0 == '0) && (held.ch == CH_ZERO);
    at_zero     = (ph0 == PH_ZERO);
    zero_x      = at_zero && is_x;
    at_digits   = (ph0 == PH_DIGITS) || (at_prefix && !prefix_zero) || (at_zero && !is_x);
    if (at_prefix && (base0 == '0)) begin
      dig_base = BASE_DEC;
    end else if (at_zero) begin
      dig_base = BASE_OCT;
    end else begin
      dig_base = base0;
    end
    dig        = digit_of(held.ch);
    dig_ok     = (held.ch != CH_NUL) && (dig < {2'b00, dig_base});
    take_digit = at_digits && dig_ok;
    emit       = at_digits && !dig_ok;
    count      = lead_hold || lead_sign || prefix_zero || zero_x || take_digit;
  end

  always_comb begin
    if (lead_hold) begin
      phase_next = PH_LEAD;
    end else if (lead_sign) begin
      phase_next = PH_PREFIX;
    end else if (prefix_zero) begin
      phase_next = PH_ZERO;
    end else if (zero_x || take_digit) begin
      phase_next = PH_DIGITS;
    end else if (emit) begin
      phase_next = PH_DONE;
    end else begin
      phase_next = ph0;
    end
  end

  always_comb begin
    negative_next = lead_sign ? (held.ch == CH_MINUS) : neg0;
    if (zero_x) begin
      active_base_next = BASE_HEX;
    end else if (at_digits) begin
      active_base_next = dig_base;
    end else begin
      active_base_next = base0;
    end
    if (take_digit) begin
      accumulator_next = acc0 * {58'd0, dig_base} + {56'd0, dig};
    end else begin
      accumulator_next = acc0;
    end
    if (count && (cnt0 != '1)) begin
      consumed_next = cnt0 + OFFSET_BITS'(1);
    end else begin
      consumed_next = cnt0;
    end
    cnt_ext = {16'd0, cnt0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DONE;
      negative    <= 1'b0;
      active_base <= '0;
      accumulator <= '0;
      consumed    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        phase       <= phase_next;
        negative    <= negative_next;
        active_base <= active_base_next;
        accumulator <= accumulator_next;
        consumed    <= consumed_next;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (step && emit) begin
      out_value  <= neg0 ? -$signed(acc0) : $signed(acc0);
      out_offset <= cnt_ext[15:0];
    end
  end

  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.end_offset = out_offset;

endmodule

`default_nettype wire

// ===== hdl/string_to_integer_parser.sv =====
// string_to_integer_parser: top level of the streaming strtol-style integer parser.
// Depends on s2i_pkg, s2i_in_if, s2i_out_if, s2i_in_stage and s2i_core.
//
// One character per beat on chars; a beat with start_req begins a new string and samples
// radix (0 detects 0x/0X hex, a leading 0 octal, else decimal). Leading spaces and tabs
// and one sign are skipped, digits and letters below the base accumulate modulo 2^64,
// and the first other character (NUL included) yields one beat on results with the
// signed value and the offset of that character, saturating at 2^OFFSET_BITS-1 and
// reported in 16 bits. Characters after the stop give nothing until the next start.
// The block takes one character every cycle while no stalled result holds the core: each
// beat passes an input register, then a single 64x6 multiply-add updates the state and
// loads the result register. A stalled result holds the core, and the input register
// still takes one more beat.
`default_nettype none

module string_to_integer_parser #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  s2i_in_if.sink    chars,
  s2i_out_if.source results
);
  import s2i_pkg::*;

  s2i_item_t held;
  logic      advance;

  s2i_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .held    (held)
  );

  s2i_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .held    (held),
    .advance (advance),
    .results (results)
  );

endmodule

`default_nettype wire

// ===== hdl/s2i_checker.sv =====
// s2i_checker: port-level assertions for string_to_integer_parser, bound to the top level.
// No package dependency; sees the channel signals only.
`default_nettype none

module s2i_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] value,
  input wire logic [15:0] end_offset
);

  // a stalled result keeps its beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(end_offset))
    else $error("result changed while stalled");

  // nothing can reach the result register after reset before a beat has passed the input register
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid)
    else $error("result beat too soon after reset");

  // with no pending result the core always advances, so input is taken
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // with no pending result an idle input side is never blocked: ready does not depend on valid
  a_ready_indep: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid |-> in_ready)
    else $error("input not ready while idle");

endmodule

bind string_to_integer_parser s2i_checker u_s2i_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .value      (results.value),
  .end_offset (results.end_offset)
);

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench of string_to_integer_parser, with an inline parse predictor,
// directed, overflow, back-pressure and random string tests.
// Depends on s2i_pkg, s2i_in_if, s2i_out_if and the parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s2i_pkg::*;

  localparam int OFFSET_BITS   = 16;
  localparam int RANDOM_ITEMS  = 650;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int DRAIN_TAIL    = 10;

  typedef struct {
    logic signed [63:0] value;
    logic        [15:0] end_offset;
  } parse_t;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SLOW} sink_mode_t;

  logic clk;
  logic rst;

  s2i_in_if  chars_if ();
  s2i_out_if results_if ();

  string_to_integer_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .results(results_if)
  );

  parse_t pending_parses[$];
  parse_t oldest;
  int     err_count   = 0;
  int     parse_count = 0;
  int     char_count  = 0;
  int     burst_left  = 0;
  bit     gaps_on     = 1'b1;
  bit     long_hold_req = 1'b0;

  phase_t      pp_phase = PH_DONE;
  logic        pp_neg   = 1'b0;
  logic [5:0]  pp_base  = '0;
  logic [63:0] pp_acc   = '0;
  logic [31:0] pp_count = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void bump_count();
    if (pp_count < (32'd1 << OFFSET_BITS) - 32'd1) begin
      pp_count = pp_count + 32'd1;
    end
  endfunction

  function automatic logic [7:0] char_weight(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      return c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      return c - CH_UA + 8'd10;
    end
    return DIGIT_NONE;
  endfunction

  // one accepted character: advance the expected parse, queue a result on the stop
  function automatic void advance_parse(input logic [7:0] c, input logic st,
                                        input logic [5:0] rdx);
    logic [7:0] w;
    parse_t     res;
    if (st) begin
      pp_phase = PH_LEAD;
      pp_neg   = 1'b0;
      pp_base  = rdx;
      pp_acc   = '0;
      pp_count = '0;
    end
    if (pp_phase == PH_DONE) return;
    if (pp_phase == PH_LEAD) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        bump_count();
        return;
      end
      pp_phase = PH_PREFIX;
      if (c == CH_MINUS || c == CH_PLUS) begin
        pp_neg = (c == CH_MINUS);
        bump_count();
        return;
      end
    end
    if (pp_phase == PH_PREFIX) begin
      if (pp_base == 6'd0) begin
        if (c == CH_ZERO) begin
          bump_count();
          pp_phase = PH_ZERO;
          return;
        end
        pp_base = BASE_DEC;
      end
      pp_phase = PH_DIGITS;
    end
    if (pp_phase == PH_ZERO) begin
      pp_phase = PH_DIGITS;
      if (c == CH_LX || c == CH_UX) begin
        pp_base = BASE_HEX;
        bump_count();
        return;
      end
      pp_base = BASE_OCT;
    end
    w = char_weight(c);
    if (c != CH_NUL && w < {2'b00, pp_base}) begin
      pp_acc = pp_acc * {58'd0, pp_base} + {56'd0, w};
      bump_count();
      return;
    end
    res.value      = pp_neg ? 64'd0 - pp_acc : pp_acc;
    res.end_offset = pp_count[15:0];
    pending_parses.push_back(res);
    pp_phase = PH_DONE;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_char(input logic [7:0] c, input logic st, input logic [5:0] rdx);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    chars_if.valid     <= 1'b1;
    chars_if.ch        <= c;
    chars_if.start_req <= st;
    chars_if.radix     <= rdx;
    do @(posedge clk); while (!chars_if.ready);
    advance_parse(c, st, rdx);
    char_count++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic [5:0] rdx, input logic [7:0] stop);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], i == 0, rdx);
    end
    send_char(stop, s.len() == 0, rdx);
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    while (pending_parses.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_parses.size() != 0) begin
      $error("%0d results never arrived", pending_parses.size());
      err_count++;
    end
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic test_directed();
    send_string(" -12", 6'd0, CH_NUL);
    send_string("0x", 6'd0, CH_NUL);
    send_string("017", 6'd0, 8'hff);
    send_string("0", BASE_HEX, CH_LX);
    send_string("0", 6'd1, CH_TAB);
    send_string("Zz", 6'd63, 8'h7e);
    send_char(8'h71, 1'b0, 6'd5);
    send_char(CH_PLUS, 1'b1, BASE_DEC);
    send_char(8'h37, 1'b0, BASE_DEC);
    send_string("z", 6'd36, CH_NUL);
    send_string("-", 6'd0, CH_NUL);
  endtask

  task automatic test_overflow();
    send_string("18446744073709551617", BASE_DEC, CH_NUL);
    send_string("-9223372036854775809", 6'd0, CH_SPACE);
    send_string("zzzzzzzzzzzzzz", 6'd36, CH_NUL);
  endtask

  task automatic test_backpressure();
    int i;
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_char(8'(CH_ZERO + i % 10), 1'b1, BASE_DEC);
      send_char(CH_NUL, 1'b0, BASE_DEC);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned sent, pick, nlead, ndig, gbase, d, i, njunk;
    logic [5:0]  rdx;
    logic [7:0]  c;
    logic        st;
    logic [7:0]  text[$];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        rdx = 6'($urandom_range(0, 63));
        c   = 8'($urandom_range(0, 255));
        st  = ($urandom_range(0, 3) == 0);
        if (st || pp_phase != PH_DONE) sent++;
        send_char(c, st, rdx);
      end else begin
        text.delete();
        pick = $urandom_range(0, 9);
        if (pick < 4) rdx = 6'd0;
        else if (pick == 4) rdx = BASE_HEX;
        else if (pick == 5) rdx = BASE_DEC;
        else if (pick == 6) rdx = $urandom_range(0, 1) ? 6'd1 : 6'($urandom_range(37, 63));
        else rdx = 6'($urandom_range(2, 36));
        gbase = (rdx > 36) ? 36 : rdx;
        nlead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (i = 0; i < nlead; i++) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        pick = $urandom_range(0, 3);
        if (pick == 0) text.push_back(CH_MINUS);
        else if (pick == 1) text.push_back(CH_PLUS);
        if (rdx == 6'd0) begin
          pick = $urandom_range(0, 3);
          if (pick == 0) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            gbase = 16;
          end else if (pick == 1) begin
            text.push_back(CH_ZERO);
            gbase = 8;
          end else begin
            c = 8'(CH_ZERO + $urandom_range(1, 9));
            text.push_back(c);
            gbase = 10;
          end
        end
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 6);
        for (i = 0; i < ndig; i++) begin
          d = $urandom_range(0, gbase - 1);
          if (d < 10) c = 8'(CH_ZERO + d);
          else c = 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
          text.push_back(c);
        end
        c = ($urandom_range(0, 3) < 2) ? CH_NUL : 8'($urandom_range(0, 255));
        text.push_back(c);
        sent += text.size();
        for (i = 0; i < text.size(); i++) send_char(text[i], i == 0, rdx);
        njunk = $urandom_range(0, 2);
        for (i = 0; i < njunk; i++) begin
          c = 8'($urandom_range(0, 255));
          send_char(c, 1'b0, rdx);
        end
      end
    end
  endtask

  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned run, tick, hold_left;
    results_if.ready = 1'b0;
    mode = SINK_OPEN;
    run = 0;
    tick = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        results_if.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        results_if.ready <= 1'b0;
      end else begin
        if (run == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          run  = $urandom_range(20, 200);
        end
        run--;
        case (mode)
          SINK_OPEN: begin
            results_if.ready <= 1'b1;
          end
          SINK_COIN: begin
            results_if.ready <= 1'($urandom_range(0, 1));
          end
          SINK_PERIODIC: begin
            results_if.ready <= (tick % 5) != 3;
          end
          default: begin
            results_if.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_parses.size() == 0) begin
        $error("unexpected result: value %0d, end_offset %0d",
               results_if.value, results_if.end_offset);
        err_count++;
      end else begin
        oldest = pending_parses.pop_front();
        parse_count++;
        if (results_if.value !== oldest.value) begin
          $error("value: expected %0d, actual %0d", oldest.value, results_if.value);
          err_count++;
        end
        if (results_if.end_offset !== oldest.end_offset) begin
          $error("end_offset: expected %0d, actual %0d",
                 oldest.end_offset, results_if.end_offset);
          err_count++;
        end
      end
    end
  end

  initial begin : run_tests
    chars_if.valid     = 1'b0;
    chars_if.ch        = '0;
    chars_if.start_req = 1'b0;
    chars_if.radix     = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    chars_if.valid <= 1'b0;
    wait_drain();
    $display("Checked %0d parsed values from %0d characters with %0d mismatches.",
             parse_count, char_count, err_count);
    $display("Covered signs, prefixes, odd bases, wraparound, restarts and stalls.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
